[rtl/route_request_cache_assert.svh]
// assertion macros for the route request cache
// used by the top level, expects signals clock and reset in scope
`ifndef ROUTE_REQUEST_CACHE_ASSERT_SVH
`define ROUTE_REQUEST_CACHE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define RRC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence in the cycle after the antecedent
`define RRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rrc_pkg.sv]
// shared types and codes for the route request cache
// no dependencies
package rrc_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int OP_W     = 3;
   localparam int ADDR_W   = 32;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE      = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY       = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_REPLIED = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT       = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] requestor;
      logic [ID_W-1:0]   req_id;
      logic              replied;
   } entry_type;

   typedef struct packed {
      logic              cmp;
      logic              ins;
      logic              rem;
      logic              set;
      logic [ADDR_W-1:0] requestor;
      logic [ID_W-1:0]   req_id;
      logic              val;
   } cmd_type;

endpackage

[rtl/rrc_chan_if.sv]
// request and response channel interfaces for the route request cache
// depends on rrc_pkg
interface rrc_req_if;
   import rrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] requestor_addr;
   logic [ID_W-1:0]   request_id;
   logic              replied_value;

   modport source (output valid, output opcode, output requestor_addr,
                   output request_id, output replied_value, input ready);
   modport sink (input valid, input opcode, input requestor_addr,
                 input request_id, input replied_value, output ready);
endinterface

interface rrc_rsp_if;
   import rrc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                replied_flag;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output replied_flag,
                   output entry_count, input ready);
   modport sink (input valid, input status, input replied_flag,
                 input entry_count, output ready);
endinterface

[rtl/rrc_cell.sv]
// one slot of the request table, compares its key and shifts with neighbors
// depends on rrc_pkg
module rrc_cell (
   input  logic                clock,
   input  logic                reset,
   input  rrc_pkg::cmd_type    cmd,
   input  rrc_pkg::entry_type  prev_entry,
   input  rrc_pkg::entry_type  next_entry,
   input  logic                found_in,
   input  logic                flag_in,
   output logic                found_out,
   output logic                flag_out,
   output rrc_pkg::entry_type  entry_out
);
   import rrc_pkg::*;

   logic              valid_ff;
   logic [ADDR_W-1:0] requestor_ff;
   logic [ID_W-1:0]   req_id_ff;
   logic              replied_ff;
   logic              match_ff;
   logic              first_hit;

   assign first_hit = match_ff & ~found_in;
   assign found_out = found_in | match_ff;
   assign flag_out  = flag_in | (first_hit & replied_ff);

   assign entry_out.valid     = valid_ff;
   assign entry_out.requestor = requestor_ff;
   assign entry_out.req_id    = req_id_ff;
   assign entry_out.replied   = replied_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (cmd.cmp) begin
            match_ff <= valid_ff & (requestor_ff == cmd.requestor)
                        & (req_id_ff == cmd.req_id);
         end
         if (cmd.ins) begin
            valid_ff <= prev_entry.valid;
         end else if (cmd.rem && found_out) begin
            valid_ff <= next_entry.valid;
         end
      end
   end

   // key and flag storage, undefined until written
   always_ff @(posedge clock) begin
      if (cmd.ins) begin
         requestor_ff <= prev_entry.requestor;
         req_id_ff    <= prev_entry.req_id;
         replied_ff   <= prev_entry.replied;
      end else if (cmd.rem && found_out) begin
         requestor_ff <= next_entry.requestor;
         req_id_ff    <= next_entry.req_id;
         replied_ff   <= next_entry.replied;
      end else if (cmd.set && first_hit) begin
         replied_ff <= cmd.val;
      end
   end

endmodule

[rtl/route_request_cache.sv]
// a request transfer leads to a compare pass (S_CMP) across the cell row,
// then an update pass (S_UPD) that writes the cells and registers the response
// a new request can transfer in the update pass but not in the compare pass;
// a pending response stalls the update pass
// reset clears slot valid bits, entry count and control; keys are not cleared
module route_request_cache #(
   parameter int TABLE_DEPTH = rrc_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic     clock,
   input logic     reset,
   rrc_req_if.sink   req_chan,
   rrc_rsp_if.source rsp_chan
);
   import rrc_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OP_W-1:0]     op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [ID_W-1:0]     id_ff;
   logic                val_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;
   logic                rsp_flag_ff, flag_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [EXT_W-1:0]    count_ext;

   logic      req_xfer, upd_go, full, hit, query_flag;
   cmd_type   cmd;
   entry_type new_entry;
   entry_type cell_entry [TABLE_DEPTH];
   logic      found_chain [TABLE_DEPTH+1];
   logic      flag_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] valid_vec, valid_plus_one;

   assign upd_go   = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == S_IDLE) || upd_go;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign full     = (count_ff == CNT_W'(TABLE_DEPTH));

   assign cmd.cmp       = (state_ff == S_CMP);
   assign cmd.ins       = upd_go && (op_ff == OP_INSERT) && !full;
   assign cmd.rem       = upd_go && (op_ff == OP_REMOVE);
   assign cmd.set       = upd_go && (op_ff == OP_SET_REPLIED);
   assign cmd.requestor = addr_ff;
   assign cmd.req_id    = id_ff;
   assign cmd.val       = val_ff;

   assign new_entry.valid     = 1'b1;
   assign new_entry.requestor = addr_ff;
   assign new_entry.req_id    = id_ff;
   assign new_entry.replied   = 1'b0;

   assign found_chain[0] = 1'b0;
   assign flag_chain[0]  = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      if (i == 0) begin : g_head
         assign prev_e = new_entry;
      end else begin : g_body
         assign prev_e = cell_entry[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_next
         assign next_e = cell_entry[i+1];
      end
      rrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .found_in   (found_chain[i]),
         .flag_in    (flag_chain[i]),
         .found_out  (found_chain[i+1]),
         .flag_out   (flag_chain[i+1]),
         .entry_out  (cell_entry[i])
      );
      assign valid_vec[i] = cell_entry[i].valid;
   end

   assign hit        = found_chain[TABLE_DEPTH];
   assign query_flag = flag_chain[TABLE_DEPTH];

   always_comb begin
      status_in = STATUS_OK;
      flag_in   = 1'b0;
      count_in  = count_ff;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_QUERY: begin
            if (hit) begin
               flag_in = query_flag;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_SET_REPLIED: begin
            if (!hit) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_COUNT: begin
            status_in = STATUS_OK;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign count_ext = EXT_W'(count_in);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (req_xfer) begin
               state_in = S_CMP;
            end else if (upd_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd_go) begin
            count_ff      <= count_in;
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_in;
            rsp_flag_ff   <= flag_in;
            rsp_count_ff  <= count_ext[COUNT_W-1:0];
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request payload captured on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_chan.opcode;
         addr_ff <= req_chan.requestor_addr;
         id_ff   <= req_chan.request_id;
         val_ff  <= req_chan.replied_value;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.replied_flag = rsp_flag_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

   assign valid_plus_one = valid_vec + TABLE_DEPTH'(1);

`include "route_request_cache_assert.svh"

   `RRC_ASSERT_ALWAYS(a_valid_packed, (valid_plus_one & valid_vec) == '0, "slots not packed")
   `RRC_ASSERT_ALWAYS(a_count_match, $countones(valid_vec) == int'(count_ff), "count mismatch")
   `RRC_ASSERT_NEXT(a_full_reject, upd_go && op_ff == OP_INSERT && full,
      rsp_status_ff == STATUS_FULL && $stable(count_ff), "full insert not rejected")
   `RRC_ASSERT_NEXT(a_xfer_cmp, req_xfer, state_ff == S_CMP, "transfer without compare")

endmodule

[sim/testbench.sv]
// self-checking testbench for route_request_cache: directed, table-full, backpressure and
// random request traffic, each response checked against a newest-first table predictor
// depends on rrc_pkg, rrc_req_if / rrc_rsp_if and the route_request_cache rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrc_pkg::*;

   localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 930;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
      logic              replied;
   } table_entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                flag;
      logic [COUNT_W-1:0]  entries;
   } cache_response_type;

   logic clock;
   logic reset;

   rrc_req_if req_bus ();
   rrc_rsp_if rsp_bus ();

   route_request_cache #(.TABLE_DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   table_entry_type    cache_entries[$];
   cache_response_type expected_rsp[$];

   logic [ADDR_W-1:0] pool_addr[3];
   logic [ID_W-1:0]   pool_id[3];

   logic quiet_mode;
   logic hold_request;
   int   hold_left;
   int   stall_left;
   int   cycle_count;
   int   error_count;
   int   requests_sent;
   int   responses_checked;
   int   full_hits;
   int   miss_hits;
   int   flag_hits;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // response sink readiness: long hold on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_bus.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // newest-first table: front of the queue is the newest entry
   function automatic cache_response_type apply_request(input logic [OP_W-1:0] op,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [ID_W-1:0] id,
                                                        input logic val);
      cache_response_type result;
      table_entry_type    fresh;
      int                 hit;
      int                 i;
      result.status = STATUS_OK;
      result.flag   = 1'b0;
      hit = -1;
      for (i = 0; i < cache_entries.size() && hit < 0; i++) begin
         if (cache_entries[i].addr == addr && cache_entries[i].id == id) hit = i;
      end
      case (op)
         OP_INSERT: begin
            if (cache_entries.size() >= DEPTH) begin
               result.status = STATUS_FULL;
            end else begin
               fresh.addr    = addr;
               fresh.id      = id;
               fresh.replied = 1'b0;
               cache_entries.push_front(fresh);
            end
         end
         OP_REMOVE: begin
            if (hit < 0) result.status = STATUS_NOT_FOUND;
            else cache_entries.delete(hit);
         end
         OP_QUERY: begin
            if (hit < 0) result.status = STATUS_NOT_FOUND;
            else result.flag = cache_entries[hit].replied;
         end
         OP_SET_REPLIED: begin
            if (hit < 0) result.status = STATUS_NOT_FOUND;
            else cache_entries[hit].replied = val;
         end
         default: begin
         end
      endcase
      result.entries = COUNT_W'(cache_entries.size());
      if (result.status == STATUS_FULL) full_hits++;
      if (result.status == STATUS_NOT_FOUND) miss_hits++;
      if (result.flag) flag_hits++;
      return result;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [ID_W-1:0] id, input logic val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= op;
      req_bus.requestor_addr <= addr;
      req_bus.request_id     <= id;
      req_bus.replied_value  <= val;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsp.push_back(apply_request(op, addr, id, val));
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_response
      cache_response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_checked++;
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response transfer with none expected, status %0d count %0d",
                     $time, rsp_bus.status, rsp_bus.entry_count);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
            end
            if (rsp_bus.replied_flag !== want.flag) begin
               error_count++;
               $display("%0t: replied_flag expected %0d actual %0d",
                        $time, want.flag, rsp_bus.replied_flag);
            end
            if (rsp_bus.entry_count !== want.entries) begin
               error_count++;
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entries, rsp_bus.entry_count);
            end
         end
      end
   end

   task automatic pick_pool_key(output logic [ADDR_W-1:0] addr, output logic [ID_W-1:0] id);
      addr = pool_addr[$urandom_range(0, 2)];
      id   = pool_id[$urandom_range(0, 2)];
      // near miss on one key bit
      if ($urandom_range(0, 9) == 0) addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
      if ($urandom_range(0, 9) == 0) id[$urandom_range(0, ID_W - 1)] ^= 1'b1;
   endtask

   task automatic pick_live_key(output logic [ADDR_W-1:0] addr, output logic [ID_W-1:0] id);
      int idx;
      if (cache_entries.size() != 0 && $urandom_range(0, 3) != 0) begin
         idx  = $urandom_range(0, cache_entries.size() - 1);
         addr = cache_entries[idx].addr;
         id   = cache_entries[idx].id;
      end else begin
         pick_pool_key(addr, id);
      end
   endtask

   task automatic test_basic_ops();
      send_request(OP_COUNT, '0, '0, 1'b0);
      send_request(OP_QUERY, '0, '0, 1'b0);
      send_request(OP_REMOVE, '1, '1, 1'b0);
      send_request(OP_SET_REPLIED, '0, '0, 1'b1);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
         send_request(OP_W'(op), '1, '1, 1'b1);
      send_request(OP_INSERT, '0, '0, 1'b0);
      send_request(OP_INSERT, '1, '1, 1'b1);
      send_request(OP_INSERT, '1, '0, 1'b0);
      send_request(OP_QUERY, '1, '1, 1'b0);
      send_request(OP_SET_REPLIED, '1, '1, 1'b1);
      send_request(OP_QUERY, '1, '1, 1'b0);
      send_request(OP_QUERY, '0, '1, 1'b0);
      // duplicate key: the newest copy shadows the older one
      send_request(OP_INSERT, '1, '1, 1'b0);
      send_request(OP_QUERY, '1, '1, 1'b0);
      send_request(OP_REMOVE, '1, '1, 1'b0);
      send_request(OP_QUERY, '1, '1, 1'b0);
      send_request(OP_SET_REPLIED, '0, '0, 1'b0);
      send_request(OP_REMOVE, '0, '0, 1'b0);
      send_request(OP_COUNT, '0, '0, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_table_full();
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
      while (cache_entries.size() < DEPTH) begin
         addr = $urandom();
         id   = $urandom_range(0, 3);
         send_request(OP_INSERT, addr, id, 1'b0);
      end
      send_request(OP_INSERT, $urandom(), $urandom(), 1'b0);
      send_request(OP_SET_REPLIED, cache_entries[DEPTH - 1].addr,
                   cache_entries[DEPTH - 1].id, 1'b1);
      send_request(OP_QUERY, cache_entries[DEPTH - 1].addr, cache_entries[DEPTH - 1].id, 1'b0);
      send_request(OP_REMOVE, cache_entries[DEPTH - 1].addr, cache_entries[DEPTH - 1].id, 1'b0);
      send_request(OP_REMOVE, cache_entries[DEPTH / 2].addr, cache_entries[DEPTH / 2].id, 1'b0);
      send_request(OP_REMOVE, cache_entries[0].addr, cache_entries[0].id, 1'b0);
      send_request(OP_QUERY, cache_entries[$].addr, cache_entries[$].id, 1'b0);
      send_request(OP_INSERT, '1, '0, 1'b0);
      send_request(OP_COUNT, '0, '0, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
      logic [OP_W-1:0]   op;
      hold_request <= 1'b1;
      quiet_mode   <= 1'b1;
      @(posedge clock);
      repeat (24) begin
         pick_live_key(addr, id);
         case ($urandom_range(0, 3))
            0: op = OP_INSERT;
            1: op = OP_REMOVE;
            2: op = OP_QUERY;
            default: op = OP_COUNT;
         endcase
         send_request(op, addr, id, $urandom_range(0, 1));
      end
      quiet_mode <= 1'b0;
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   id;
      logic [OP_W-1:0]   op;
      int                r;
      int                ins_pct;
      int                i;
      for (i = 0; i < 3; i++) begin
         pool_addr[i] = $urandom();
         pool_id[i]   = $urandom();
      end
      for (i = 0; i < n_items; i++) begin
         if (i % 40 == 0) quiet_mode <= ($urandom_range(0, 3) == 0);
         ins_pct = (cache_entries.size() >= DEPTH - 2) ? 20 : 35;
         r = $urandom_range(0, 99);
         pick_pool_key(addr, id);
         if (r < ins_pct) begin
            op = OP_INSERT;
         end else if (r < 55) begin
            op = OP_REMOVE;
            pick_live_key(addr, id);
         end else if (r < 68) begin
            op = OP_QUERY;
            pick_live_key(addr, id);
         end else if (r < 81) begin
            op = OP_SET_REPLIED;
            pick_live_key(addr, id);
         end else if (r < 86) begin
            op = OP_COUNT;
         end else if (r < 90) begin
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end else begin
            op   = OP_W'($urandom_range(0, (1 << OP_W) - 1));
            addr = $urandom();
            id   = $urandom();
         end
         send_request(op, addr, id, $urandom_range(0, 1));
      end
      quiet_mode <= 1'b0;
      wait_for_drain();
   endtask

   initial begin
      reset                  = 1'b1;
      quiet_mode             = 1'b0;
      hold_request           = 1'b0;
      hold_left              = 0;
      stall_left             = 0;
      cycle_count            = 0;
      error_count            = 0;
      requests_sent          = 0;
      responses_checked      = 0;
      full_hits              = 0;
      miss_hits              = 0;
      flag_hits              = 0;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = OP_COUNT;
      req_bus.requestor_addr = '0;
      req_bus.request_id     = '0;
      req_bus.replied_value  = 1'b0;
      rsp_bus.ready          = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_table_full();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      $display("run covered %0d requests and %0d checked responses", requests_sent,
               responses_checked);
      $display("table-full rejects %0d, key misses %0d, replied flags seen %0d",
               full_hits, miss_hits, flag_hits);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
